### design/nearest_palette_color_search_top_macros.svh
// Assertion macros for the nearest palette color search block.
// Used by the port-level checker; no other dependencies.
`ifndef NEAREST_PALETTE_COLOR_SEARCH_TOP_MACROS_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_TOP_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define NPCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define NPCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/npcs_pkg.sv
// Shared types and constants for the nearest palette color search block.
// No dependencies; every other design file except the macros header refers to it by scoped names.
`default_nettype none

package npcs_pkg;

    localparam int COLOR_W    = 8;
    localparam int ENTRY_W    = 4;
    localparam int COUNT_W    = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int SQ_W       = 2 * COLOR_W;
    localparam int DIST_W     = SQ_W + 2;

    localparam logic CMD_CLASSIFY = 1'b0;
    localparam logic CMD_LOAD     = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_COUNT   = 1'd1;

    typedef struct packed {
        logic               command;
        logic [ENTRY_W-1:0] entry_index;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] alpha;
    } npcs_req_t;

    typedef struct packed {
        logic               matched;
        logic [ENTRY_W-1:0] nearest_idx;
    } npcs_rsp_t;

    // Controller to datapath.
    typedef struct packed {
        logic start;
        logic load_wr;
        logic issue;
        logic finish;
    } npcs_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic reject;
        logic last_issue;
        logic pipe_busy;
        logic out_free;
    } npcs_status_t;

endpackage

`default_nettype wire

### design/npcs_ctrl.sv
// Sequencer for the nearest palette color search block.
// Depends on npcs_pkg for the command and status structs.
`default_nettype none

module npcs_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    input  wire logic                  req_command,
    output logic                       req_stall,
    input  wire npcs_pkg::npcs_status_t status,
    output npcs_pkg::npcs_cmd_t        cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.load_wr = accept && (req_command == npcs_pkg::CMD_LOAD);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_command == npcs_pkg::CMD_CLASSIFY))
                begin
                    cmd.start  = 1'b1;
                    state_next = status.reject ? ST_FINISH : ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                cmd.issue = 1'b1;
                if (status.last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // hold until the result register can take the transaction
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### design/npcs_datapath.sv
// Palette memory, config registers, distance pipeline and result register.
// Depends on npcs_pkg; driven by npcs_ctrl through command and status structs.
`default_nettype none

module npcs_datapath #(
    parameter int PALETTE_DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire npcs_pkg::npcs_req_t                   req,
    input  wire logic                                  cfg_write,
    input  wire logic [npcs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [npcs_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire npcs_pkg::npcs_cmd_t                   cmd,
    output npcs_pkg::npcs_status_t                     status,
    output logic                                       rsp_valid,
    input  wire logic                                  rsp_stall,
    output npcs_pkg::npcs_rsp_t                        rsp
);

    localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > npcs_pkg::COUNT_W) ? CNT_W : npcs_pkg::COUNT_W;
    localparam int RGB_W = 3 * npcs_pkg::COLOR_W;
    localparam int C_W   = npcs_pkg::COLOR_W;

    logic [npcs_pkg::COLOR_W-1:0] alpha_thr_reg;
    logic [npcs_pkg::COUNT_W-1:0] count_cfg_reg;

    logic [RGB_W-1:0] palette_mem_reg [PALETTE_DEPTH];

    logic [C_W-1:0]   pix_r_reg;
    logic [C_W-1:0]   pix_g_reg;
    logic [C_W-1:0]   pix_b_reg;
    logic             matched_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] addr_reg;

    logic             v1_reg;
    logic [IDX_W-1:0] idx1_reg;
    logic [RGB_W-1:0] rd_reg;

    logic                          v2_reg;
    logic [IDX_W-1:0]              idx2_reg;
    logic [npcs_pkg::SQ_W-1:0]     sq_r_reg;
    logic [npcs_pkg::SQ_W-1:0]     sq_g_reg;
    logic [npcs_pkg::SQ_W-1:0]     sq_b_reg;

    logic                          first_reg;
    logic [npcs_pkg::DIST_W-1:0]   best_dist_reg;
    logic [IDX_W-1:0]              best_idx_reg;

    logic                          out_valid_reg;
    npcs_pkg::npcs_rsp_t           out_reg;

    logic [CMP_W-1:0]              count_ext;
    logic [CMP_W-1:0]              depth_ext;
    logic [CMP_W-1:0]              entry_ext;
    logic [CMP_W-1:0]              cnt_sat;
    logic [CNT_W-1:0]              cnt_use;
    logic [C_W-1:0]                diff_r;
    logic [C_W-1:0]                diff_g;
    logic [C_W-1:0]                diff_b;
    logic [C_W-1:0]                mem_r;
    logic [C_W-1:0]                mem_g;
    logic [C_W-1:0]                mem_b;
    logic [npcs_pkg::DIST_W-1:0]   dist_sum;
    logic [IDX_W+npcs_pkg::ENTRY_W-1:0] best_ext;

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_thr_reg <= '0;
            count_cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                npcs_pkg::REG_ALPHA_THRESHOLD: alpha_thr_reg <= cfg_data;
                npcs_pkg::REG_PALETTE_COUNT:   count_cfg_reg <= cfg_data[npcs_pkg::COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign count_ext = CMP_W'(count_cfg_reg);
    assign depth_ext = CMP_W'(PALETTE_DEPTH);
    assign entry_ext = CMP_W'(req.entry_index);
    assign cnt_sat   = (count_ext > depth_ext) ? depth_ext : count_ext;
    assign cnt_use   = cnt_sat[CNT_W-1:0];

    assign status.reject     = (cnt_use == '0) || (req.alpha < alpha_thr_reg);
    assign status.last_issue = (addr_reg == cnt_reg - CNT_W'(1));
    assign status.pipe_busy  = v1_reg || v2_reg;
    assign status.out_free   = !out_valid_reg || !rsp_stall;

    // Palette memory: one write port for loads, one registered read for the search
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && (entry_ext < depth_ext))
        begin
            palette_mem_reg[entry_ext[IDX_W-1:0]] <= {req.red, req.green, req.blue};
        end
        if (cmd.issue)
        begin
            rd_reg <= palette_mem_reg[addr_reg[IDX_W-1:0]];
        end
    end

    // Pixel and search bookkeeping
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            pix_r_reg   <= req.red;
            pix_g_reg   <= req.green;
            pix_b_reg   <= req.blue;
            matched_reg <= !status.reject;
            cnt_reg     <= cnt_use;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                addr_reg <= '0;
            end
            else if (cmd.issue)
            begin
                addr_reg <= addr_reg + CNT_W'(1);
            end
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
        end
    end

    // Stage 2: per-channel squared differences
    assign mem_r  = rd_reg[3*C_W-1:2*C_W];
    assign mem_g  = rd_reg[2*C_W-1:C_W];
    assign mem_b  = rd_reg[C_W-1:0];
    assign diff_r = (pix_r_reg > mem_r) ? (pix_r_reg - mem_r) : (mem_r - pix_r_reg);
    assign diff_g = (pix_g_reg > mem_g) ? (pix_g_reg - mem_g) : (mem_g - pix_g_reg);
    assign diff_b = (pix_b_reg > mem_b) ? (pix_b_reg - mem_b) : (mem_b - pix_b_reg);

    always_ff @(posedge clk)
    begin
        idx1_reg <= addr_reg[IDX_W-1:0];
        idx2_reg <= idx1_reg;
        sq_r_reg <= npcs_pkg::SQ_W'(diff_r) * npcs_pkg::SQ_W'(diff_r);
        sq_g_reg <= npcs_pkg::SQ_W'(diff_g) * npcs_pkg::SQ_W'(diff_g);
        sq_b_reg <= npcs_pkg::SQ_W'(diff_b) * npcs_pkg::SQ_W'(diff_b);
    end

    // Stage 3: sum and keep the running minimum; strict compare keeps the lowest index on ties
    assign dist_sum = npcs_pkg::DIST_W'(sq_r_reg) + npcs_pkg::DIST_W'(sq_g_reg)
                    + npcs_pkg::DIST_W'(sq_b_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b1;
        end
        else if (cmd.start)
        begin
            first_reg <= 1'b1;
        end
        else if (v2_reg)
        begin
            first_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            best_idx_reg <= '0;
        end
        else if (v2_reg && (first_reg || (dist_sum < best_dist_reg)))
        begin
            best_dist_reg <= dist_sum;
            best_idx_reg  <= idx2_reg;
        end
    end

    assign best_ext = {npcs_pkg::ENTRY_W'(0), best_idx_reg};

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_reg.matched     <= matched_reg;
            out_reg.nearest_idx <= matched_reg ? best_ext[npcs_pkg::ENTRY_W-1:0] : '0;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

`default_nettype wire

### design/nearest_palette_color_search_top.sv
// Nearest palette color search: a palette of RGB entries is loaded one entry per
// load transaction; a classify transaction returns the index of the closest entry by
// squared RGB distance (lowest index on ties), or an unmatched result when the palette
// count is zero or the pixel alpha is below the threshold. A load gives no result and
// does not hold off the next transaction. A rejected classify skips the search, goes
// straight to the finish step and takes the next transaction once its result is moved
// into the output register. A searched classify compares one palette entry per cycle,
// with N = min(palette_count, PALETTE_DEPTH) entries searched: the N reads, then a
// drain of the read, square and compare stages, and last the move of the result into
// the output register, before the next transaction is taken. A finished result waits in
// the output register, so the next transaction is taken while the previous result is
// still stalled; a later finished result waits until that register is free.
// Unloaded entries below the count read as garbage.
`default_nettype none

module nearest_palette_color_search_top #(
    parameter int PALETTE_DEPTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             req_valid,
    output logic                                  req_stall,
    input  wire npcs_pkg::npcs_req_t              req,
    output logic                                  rsp_valid,
    input  wire logic                             rsp_stall,
    output npcs_pkg::npcs_rsp_t                   rsp,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [npcs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [npcs_pkg::CFG_DATA_W-1:0]  cfg_data
);

    npcs_pkg::npcs_cmd_t    cmd;
    npcs_pkg::npcs_status_t status;

    assign cfg_ready = 1'b1;

    npcs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_command (req.command),
        .req_stall   (req_stall),
        .status      (status),
        .cmd         (cmd)
    );

    npcs_datapath #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

### design/npcs_checker.sv
// Port-level checker for the nearest palette color search block, bound to the top.
// Depends on npcs_pkg and nearest_palette_color_search_top_macros.svh.
`default_nettype none
`include "nearest_palette_color_search_top_macros.svh"

module npcs_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                req_valid,
    input wire logic                req_stall,
    input wire npcs_pkg::npcs_req_t req,
    input wire logic                rsp_valid,
    input wire logic                rsp_stall,
    input wire npcs_pkg::npcs_rsp_t rsp
);

    `NPCS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled result changed")
    `NPCS_ASSERT_NOW(a_unmatched_zero, rsp_valid && !rsp.matched, rsp.nearest_idx == '0, "unmatched result with nonzero index")
    `NPCS_ASSERT_NEXT(a_load_no_stall, req_valid && !req_stall && (req.command == npcs_pkg::CMD_LOAD), !req_stall, "load transaction stalled the next one")
    `NPCS_ASSERT_NEXT(a_classify_busy, req_valid && !req_stall && (req.command == npcs_pkg::CMD_CLASSIFY), req_stall, "classify transaction did not occupy the block")

endmodule

bind nearest_palette_color_search_top npcs_checker u_npcs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire
